// ===== hw/rtl/sorted_set_insert_delete_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted set unit
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_SET_INSERT_DELETE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSET_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sset assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define SSET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sset assertion failed (next cycle)");

`endif

// ===== hw/rtl/sset_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted set package
// Sizes, status codes and cell interface types shared by the unit.
// ---------------------------------------------------------------------------
package sset_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int STATUS_W    = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic   ins;   // committed insert this cycle
    logic   del;   // committed delete this cycle
    value_t key;
  } cell_ctl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic   lt;    // cell holds a valid value below the key
    value_t val;
  } cell_link_t;

endpackage

// ===== hw/rtl/sset_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted set cell
// One slot of the ordered chain: compares with the key and shifts in step.
// ---------------------------------------------------------------------------
module sset_cell (
  input  logic                clk,
  input  sset_pkg::cell_ctl_t ctl_i,
  input  logic                valid_i,
  input  sset_pkg::cell_link_t left_i,
  input  sset_pkg::value_t    right_val_i,
  output sset_pkg::cell_link_t link_o,
  output logic                eq_o,
  output sset_pkg::value_t    val_nxt_o
);

  sset_pkg::value_t val_r;
  sset_pkg::value_t val_nxt;
  logic             lt;

  assign lt   = valid_i && (val_r < ctl_i.key);
  assign eq_o = valid_i && (val_r == ctl_i.key);

  // Cells below the key keep their value; the rest move up on insert
  // (the first of them takes the key) and move down on delete.
  always_comb begin
    val_nxt = val_r;
    if (ctl_i.ins && !lt) begin
      val_nxt = left_i.lt ? ctl_i.key : left_i.val;
    end else if (ctl_i.del && !lt) begin
      val_nxt = right_val_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link_o.lt  = lt;
  assign link_o.val = val_r;
  assign val_nxt_o  = val_nxt;

endmodule

// ===== hw/rtl/sorted_set_insert_delete_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted set insert/delete unit
// Keeps up to 16 distinct signed values in ascending order in a chain of cells.
// ---------------------------------------------------------------------------
// The unit takes one transaction per clock while the output is not held
// back, and returns exactly one result transaction for each in the
// following cycle. An input transaction carries the operation in in_tuser
// (0 inserts, 1 deletes) and the signed value in in_tdata. All sixteen
// cells compare the value with their own content in parallel and shift by
// one place in the same cycle; the compare-and-shift across the cell chain
// sets the clock period. The result gives the status, the count after the
// operation, and the smallest and largest stored values (both zero when
// the set is empty). A single output register separates the two sides:
// a new transaction is taken while the held result is taken downstream.
// After reset the set is empty; no clearing pass is needed.
`include "sorted_set_insert_delete_unit_defines.svh"

module sorted_set_insert_delete_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] count, [36:5] smallest, [68:37] largest, zero pad
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int CAP = sset_pkg::CAPACITY;
  localparam int CW  = sset_pkg::CNT_W;

  // Count of stored values; cells below it are valid.
  logic [CW-1:0] count_r, count_nxt;

  // Output register.
  logic              out_valid_r;
  sset_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]     count_out_r;
  sset_pkg::value_t  small_r, small_nxt;
  sset_pkg::value_t  large_r, large_nxt;

  logic                 accept;
  logic                 present;
  logic                 full;
  logic                 do_ins, do_del;
  sset_pkg::cell_ctl_t  ctl;
  sset_pkg::cell_link_t links   [CAP];
  sset_pkg::value_t     val_nxts[CAP];
  logic [CAP-1:0]       eqs;
  logic [CAP-1:0]       valids;
  sset_pkg::cell_link_t left_edge;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign present = |eqs;
  assign full    = (count_r == CW'(CAP));
  assign do_ins  = accept && !in_tuser && !present && !full;
  assign do_del  = accept && in_tuser && present;

  assign ctl.ins = do_ins;
  assign ctl.del = do_del;
  assign ctl.key = in_tdata;

  // The head cell sees a virtual left neighbor below every key, so it takes
  // the key whenever its own value is not below it.
  assign left_edge.lt  = 1'b1;
  assign left_edge.val = in_tdata;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    sset_pkg::cell_link_t left;
    sset_pkg::value_t     right_val;

    assign valids[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign left = left_edge;
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = links[i+1].val;
    end

    sset_cell u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .valid_i     (valids[i]),
      .left_i      (left),
      .right_val_i (right_val),
      .link_o      (links[i]),
      .eq_o        (eqs[i]),
      .val_nxt_o   (val_nxts[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Status: the duplicate check takes priority over the full check.
  always_comb begin
    if (!in_tuser) begin
      if (present) begin
        status_nxt = sset_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_nxt = sset_pkg::ST_FULL;
      end else begin
        status_nxt = sset_pkg::ST_INSERTED;
      end
    end else begin
      status_nxt = present ? sset_pkg::ST_DELETED : sset_pkg::ST_NOT_FOUND;
    end
  end

  // Smallest is the head cell; largest is the cell just below the new count,
  // picked by an AND-OR over the chain.
  always_comb begin
    small_nxt = (count_nxt != '0) ? val_nxts[0] : '0;
    large_nxt = '0;
    for (int i = 0; i < CAP; i++) begin
      if (count_nxt == CW'(i + 1)) begin
        large_nxt = large_nxt | val_nxts[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      count_out_r <= count_nxt;
      small_r     <= small_nxt;
      large_r     <= large_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, large_r, small_r, count_out_r};

  // The stored count never goes past the capacity.
  `SSET_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAP))
  // A committed insert grows the set by exactly one.
  `SSET_ASSERT_NEXT(a_ins_count, do_ins, count_r == $past(count_r) + CW'(1))
  // A non-empty result never shows the smallest above the largest.
  `SSET_ASSERT_NOW(a_order, out_valid_r && count_out_r != '0, small_r <= large_r)

endmodule
